// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that prop holds at every clock edge outside reset.
`define ASSERT_ON(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// Check that cond never holds at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_ON(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== rtl/core/spss_pkg.sv =====
package spss_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 1024;
  localparam int unsigned DATA_W = 32;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_FOUND      = 2'd0,
    STATUS_NO_PAIR    = 2'd1,
    STATUS_NOT_SORTED = 2'd2,
    STATUS_EMPTY      = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                      cmd;
    logic signed [DATA_W-1:0]  value;
  } queue_item_t;

endpackage

// ===== rtl/core/spss_in_if.sv =====
interface spss_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ===== rtl/core/spss_out_if.sv =====
interface spss_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] first_value;
  logic signed [31:0] second_value;

  modport source (output valid, output status, output first_value, output second_value,
                  input ready);
  modport sink   (input valid, input status, input first_value, input second_value,
                  output ready);
endinterface

// ===== rtl/core/spss_front.sv =====
module spss_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  spss_in_if.sink              in_i,
  output spss_pkg::queue_item_t item_o,
  output logic                 item_valid_o,
  input  logic                 item_ready_i
);
  import spss_pkg::*;

  `include "assert_macros.svh"

  queue_item_t slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  fill_q, fill_d;
  logic        push, pop;
  queue_item_t item_in;

  always_comb begin
    item_in.cmd   = cmd_e'(in_i.cmd);
    item_in.value = in_i.value;
  end

  assign in_i.ready   = (fill_q != 2'd2);
  assign push         = in_i.valid && in_i.ready;
  assign item_valid_o = (fill_q != 2'd0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

  `ASSERT_NEVER(a_fill_range, clk_i, rst_ni, fill_q == 2'd3)
  `ASSERT_ON(a_ptr_track, clk_i, rst_ni,
             (fill_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
  `ASSERT_ON(a_ptr_even, clk_i, rst_ni,
             (fill_q != 2'd1) |-> (wr_ptr_q == rd_ptr_q))

endmodule

// ===== rtl/core/spss_back.sv =====
module spss_back #(
  parameter int unsigned MAX_ELEMENTS = spss_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  spss_pkg::queue_item_t item_i,
  input  logic                  item_valid_i,
  output logic                  item_ready_o,
  spss_out_if.source            out_o
);
  import spss_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic signed [DATA_W-1:0] mem [MAX_ELEMENTS];
  logic signed [DATA_W-1:0] rd_lo_q, rd_hi_q;
  logic                     we;
  logic [AW-1:0]            waddr;
  logic signed [DATA_W-1:0] wdata;

  logic [CW-1:0]            cnt_q, cnt_d;
  logic                     asc_q, asc_d;
  logic                     intact_q, intact_d;
  logic signed [DATA_W-1:0] prev_q, prev_d;
  logic                     closed_q, closed_d;
  logic [AW-1:0]            lo_q, lo_d;
  logic [AW-1:0]            hi_q, hi_d;
  logic signed [DATA_W-1:0] tgt_q, tgt_d;

  status_e                  res_status_q, res_status_d;
  logic signed [DATA_W-1:0] res_fst_q, res_fst_d;
  logic signed [DATA_W-1:0] res_snd_q, res_snd_d;

  logic                     out_valid_q;
  status_e                  out_status_q;
  logic signed [DATA_W-1:0] out_fst_q, out_snd_q;
  logic                     out_load;

  logic [CW-1:0]            eff_cnt;
  logic                     eff_asc;
  logic                     eff_intact;
  logic signed [DATA_W-1:0] eff_prev;
  logic signed [DATA_W:0]   sum_s;
  logic signed [DATA_W:0]   tgt_ext;
  logic [AW-1:0]            lo_n, hi_n;

  assign item_ready_o = (state_q == ST_IDLE);
  assign sum_s   = $signed({rd_lo_q[DATA_W-1], rd_lo_q}) + $signed({rd_hi_q[DATA_W-1], rd_hi_q});
  assign tgt_ext = $signed({tgt_q[DATA_W-1], tgt_q});

  always_comb begin
    eff_cnt    = closed_q ? '0 : cnt_q;
    eff_asc    = closed_q ? 1'b1 : asc_q;
    eff_intact = closed_q ? 1'b1 : intact_q;
    eff_prev   = closed_q ? '0 : prev_q;
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    asc_d        = asc_q;
    intact_d     = intact_q;
    prev_d       = prev_q;
    closed_d     = closed_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    tgt_d        = tgt_q;
    res_status_d = res_status_q;
    res_fst_d    = res_fst_q;
    res_snd_d    = res_snd_q;
    we           = 1'b0;
    waddr        = eff_cnt[AW-1:0];
    wdata        = item_i.value;
    out_load     = 1'b0;
    lo_n         = lo_q;
    hi_n         = hi_q;

    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          if (item_i.cmd == CMD_APPEND) begin
            cnt_d    = eff_cnt;
            asc_d    = eff_asc;
            intact_d = eff_intact;
            prev_d   = eff_prev;
            closed_d = 1'b0;
            if (eff_cnt < CW'(MAX_ELEMENTS)) begin
              if (eff_cnt == CW'(1)) begin
                asc_d = (eff_prev <= item_i.value);
              end else if (eff_cnt > CW'(1)) begin
                if (eff_asc ? (eff_prev > item_i.value) : (eff_prev < item_i.value)) begin
                  intact_d = 1'b0;
                end
              end
              we     = 1'b1;
              prev_d = item_i.value;
              cnt_d  = eff_cnt + CW'(1);
            end
          end else begin
            tgt_d     = item_i.value;
            closed_d  = 1'b1;
            res_fst_d = '0;
            res_snd_d = '0;
            if (cnt_q == '0) begin
              res_status_d = STATUS_EMPTY;
              lo_d         = '0;
              hi_d         = '0;
              state_d      = ST_DONE;
            end else if (!intact_q) begin
              res_status_d = STATUS_NOT_SORTED;
              lo_d         = '0;
              hi_d         = '0;
              state_d      = ST_DONE;
            end else begin
              lo_d = '0;
              hi_d = AW'(cnt_q - CW'(1));
              if (cnt_q == CW'(1)) begin
                res_status_d = STATUS_NO_PAIR;
                state_d      = ST_DONE;
              end else begin
                state_d = ST_READ;
              end
            end
          end
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (sum_s == tgt_ext) begin
          res_status_d = STATUS_FOUND;
          res_fst_d    = rd_lo_q;
          res_snd_d    = rd_hi_q;
          state_d      = ST_DONE;
        end else begin
          if (asc_q ? (sum_s > tgt_ext) : (sum_s < tgt_ext)) begin
            hi_n = hi_q - AW'(1);
          end else begin
            lo_n = lo_q + AW'(1);
          end
          lo_d = lo_n;
          hi_d = hi_n;
          if (lo_n < hi_n) begin
            state_d = ST_READ;
          end else begin
            res_status_d = STATUS_NO_PAIR;
            state_d      = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      asc_q       <= 1'b1;
      intact_q    <= 1'b1;
      prev_q      <= '0;
      closed_q    <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      asc_q    <= asc_d;
      intact_q <= intact_d;
      prev_q   <= prev_d;
      closed_q <= closed_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q        <= tgt_d;
    res_status_q <= res_status_d;
    res_fst_q    <= res_fst_d;
    res_snd_q    <= res_snd_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_fst_q    <= res_fst_q;
      out_snd_q    <= res_snd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_lo_q <= mem[lo_q];
    rd_hi_q <= mem[hi_q];
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.first_value  = out_fst_q;
  assign out_o.second_value = out_snd_q;

  `ASSERT_ON(a_read_ptr_order, clk_i, rst_ni, (state_q == ST_READ) |-> (lo_q < hi_q))
  `ASSERT_ON(a_read_in_set, clk_i, rst_ni,
             (state_q == ST_READ) |-> (CW'(hi_q) < cnt_q))
  `ASSERT_ON(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(MAX_ELEMENTS))
  `ASSERT_ON(a_cmp_next, clk_i, rst_ni,
             (state_q == ST_CMP) |=> (state_q == ST_READ || state_q == ST_DONE))

endmodule

// ===== rtl/core/sorted_pair_sum_search.sv =====
// Append: one transaction per cycle while the back end is idle, written to the
// element store from its idle state after the queue. Search: a setup step in
// the idle state, then per pointer step a registered dual-port store read, then
// a 33-bit sum compare, then a load into the output register once it is free;
// the queue takes up to two more items meanwhile and then holds input off.
// Reset: asynchronous, clears count, order flags, pointers, queue and output
// valid; the element store is not cleared and needs no clearing pass.
module sorted_pair_sum_search #(
  parameter int unsigned MAX_ELEMENTS = spss_pkg::MAX_ELEMENTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spss_in_if.sink    in_i,
  spss_out_if.source out_o
);
  import spss_pkg::*;

  queue_item_t item;
  logic        item_valid;
  logic        item_ready;

  spss_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  spss_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .out_o        (out_o)
  );

endmodule
